@@ sv/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package deq_pkg;

  localparam int unsigned CountW = 9;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW = 8;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DataW-1:0]  value;
    logic        [PosW-1:0]   position;
  } deq_in_t;

  typedef struct packed {
    logic signed [DataW-1:0]  read_value;
    status_e                  status;
    logic        [CountW-1:0] count;
    logic signed [DataW-1:0]  front_value;
    logic signed [DataW-1:0]  rear_value;
  } deq_out_t;

endpackage

@@ sv/deq_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/double_ended_queue.sv @@
// Double-ended queue of signed 32-bit values held in a ring buffer.
// A result is registered in the s2 stage, then in the output register; a stall can hold it.
// One command is accepted per cycle while in_stall_o is low; each uses at most one ring access.
// Front and rear values live in registers; pops and reads fetch one ring entry.
// Reset clears the pointers, the count and the pipeline valids; ring contents stay as they are.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  deq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output deq_out_t out_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = ((CW > PosW) ? CW : PosW) + 1;
  localparam logic [PW-1:0] Last = PW'(DEPTH - 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == Last) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    ring_prev = (p == '0) ? Last : p - PW'(1);
  endfunction

  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          in_accept, s2_adv;
  status_e       st_d;
  logic          we, re;
  logic [PW-1:0] waddr, raddr;
  logic [SW-1:0] pos_s, cnt_s, idx_sum;

  logic          s2_valid_q;
  cmd_e          s2_cmd_q;
  status_e       s2_status_q;
  logic [CW-1:0] s2_cnt_q;
  logic signed [DataW-1:0] s2_value_q;
  logic [DataW-1:0]        rdata;

  logic signed [DataW-1:0] front_q, front_d, rear_q, rear_d, rd_val;
  logic     out_valid_q;
  deq_out_t out_data_q;

  assign s2_adv     = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s2_valid_q && !s2_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pos_s   = SW'(in_data_i.position);
  assign cnt_s   = SW'(cnt_q);
  assign idx_sum = SW'(head_q) + pos_s;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    st_d   = ST_OK;
    we     = 1'b0;
    re     = 1'b0;
    waddr  = tail_q;
    raddr  = head_q;
    case (in_data_i.cmd)
      CMD_PUSH_FRONT: begin
        if (cnt_q >= Full) begin
          st_d = ST_FULL;
        end else begin
          head_d = ring_prev(head_q);
          waddr  = ring_prev(head_q);
          we     = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (cnt_q >= Full) begin
          st_d = ST_FULL;
        end else begin
          tail_d = ring_next(tail_q);
          waddr  = tail_q;
          we     = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (cnt_q == '0) begin
          st_d = ST_EMPTY;
        end else begin
          head_d = ring_next(head_q);
          raddr  = ring_next(head_q);
          re     = 1'b1;
          cnt_d  = cnt_q - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (cnt_q == '0) begin
          st_d = ST_EMPTY;
        end else begin
          tail_d = ring_prev(tail_q);
          raddr  = ring_prev(ring_prev(tail_q));
          re     = 1'b1;
          cnt_d  = cnt_q - CW'(1);
        end
      end
      CMD_READ: begin
        if (pos_s >= cnt_s) begin
          st_d = ST_RANGE;
        end else begin
          raddr = (idx_sum >= DepthS) ? PW'(idx_sum - DepthS) : PW'(idx_sum);
          re    = 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_d = '0;
        tail_d = '0;
        cnt_d  = '0;
      end
      default: begin
      end
    endcase
  end

  deq_ram #(
    .Width(DataW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.value),
    .re_i    (in_accept && re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    rd_val  = '0;
    if (s2_status_q == ST_OK) begin
      case (s2_cmd_q)
        CMD_PUSH_FRONT: begin
          front_d = s2_value_q;
          if (s2_cnt_q == CW'(1)) begin
            rear_d = s2_value_q;
          end
        end
        CMD_PUSH_BACK: begin
          rear_d = s2_value_q;
          if (s2_cnt_q == CW'(1)) begin
            front_d = s2_value_q;
          end
        end
        CMD_POP_FRONT: front_d = rdata;
        CMD_POP_BACK:  rear_d  = rdata;
        CMD_READ:      rd_val  = rdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
      end
      s2_valid_q <= in_accept || (s2_valid_q && !s2_adv);
      if (s2_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s2_cmd_q    <= in_data_i.cmd;
      s2_status_q <= st_d;
      s2_cnt_q    <= cnt_d;
      s2_value_q  <= in_data_i.value;
    end
    if (s2_adv) begin
      front_q                 <= front_d;
      rear_q                  <= rear_d;
      out_data_q.read_value   <= rd_val;
      out_data_q.status       <= s2_status_q;
      out_data_q.count        <= CountW'(s2_cnt_q);
      out_data_q.front_value  <= (s2_cnt_q == '0) ? '0 : front_d;
      out_data_q.rear_value   <= (s2_cnt_q == '0) ? '0 : rear_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ sv/deq_checker.sv @@
// Port-level assertions for the double-ended queue and their binding.
module deq_checker
  import deq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input deq_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input deq_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("A stalled result item changed or was dropped.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.count == '0 |->
      out_data_o.front_value == '0 && out_data_o.rear_value == '0)
    else $error("An empty queue reported nonzero front or rear values.");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |-> out_data_o.count == '0)
    else $error("An empty status came with a nonzero count.");

  a_fail_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.read_value == '0)
    else $error("A failed command returned a nonzero read value.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("An accepted item did not produce a result in time.");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

@@ bench/deq_result_checker.sv @@
// Result checker for the double-ended queue: predicts each result and compares it.
module deq_result_checker
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  deq_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  deq_out_t out_data_i,
  output int       errors_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingDepth = 256;

  logic signed [DataW-1:0] ring_q [RingDepth];
  logic [PosW-1:0]         head_q;
  logic [PosW-1:0]         tail_q;
  logic [CountW-1:0]       fill_q;
  deq_out_t                pending_results [$];
  int unsigned             result_idx;

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("mismatch in %s on result %0d: got %h, expected %h", what, result_idx,
             got, want);
    errors_o++;
  endtask

  function automatic deq_out_t next_deq_result(input deq_in_t item);
    deq_out_t        res;
    logic [PosW-1:0] idx;
    res = '0;
    res.status = ST_OK;
    case (item.cmd)
      CMD_PUSH_FRONT: begin
        if (fill_q == CountW'(RingDepth)) begin
          res.status = ST_FULL;
        end else begin
          head_q = head_q - PosW'(1);
          ring_q[head_q] = item.value;
          fill_q = fill_q + CountW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (fill_q == CountW'(RingDepth)) begin
          res.status = ST_FULL;
        end else begin
          ring_q[tail_q] = item.value;
          tail_q = tail_q + PosW'(1);
          fill_q = fill_q + CountW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (fill_q == '0) begin
          res.status = ST_EMPTY;
        end else begin
          head_q = head_q + PosW'(1);
          fill_q = fill_q - CountW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (fill_q == '0) begin
          res.status = ST_EMPTY;
        end else begin
          tail_q = tail_q - PosW'(1);
          fill_q = fill_q - CountW'(1);
        end
      end
      CMD_READ: begin
        if (CountW'(item.position) >= fill_q) begin
          res.status = ST_RANGE;
        end else begin
          idx = head_q + item.position;
          res.read_value = ring_q[idx];
        end
      end
      CMD_CLEAR: begin
        head_q = '0;
        tail_q = '0;
        fill_q = '0;
      end
      default: begin
      end
    endcase
    res.count = fill_q;
    if (fill_q != '0) begin
      idx = tail_q - PosW'(1);
      res.front_value = ring_q[head_q];
      res.rear_value = ring_q[idx];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deq_out_t want;
    if (!rst_ni) begin
      head_q = '0;
      tail_q = '0;
      fill_q = '0;
      pending_results.delete();
      result_idx = 0;
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        pending_results.push_back(next_deq_result(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no command waiting", out_data_i.read_value, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data_i.read_value !== want.read_value) begin
            report_mismatch("read_value", out_data_i.read_value, want.read_value);
          end
          if (out_data_i.status !== want.status) begin
            report_mismatch("status", DataW'(out_data_i.status), DataW'(want.status));
          end
          if (out_data_i.count !== want.count) begin
            report_mismatch("count", DataW'(out_data_i.count), DataW'(want.count));
          end
          if (out_data_i.front_value !== want.front_value) begin
            report_mismatch("front_value", out_data_i.front_value, want.front_value);
          end
          if (out_data_i.rear_value !== want.rear_value) begin
            report_mismatch("rear_value", out_data_i.rear_value, want.rear_value);
          end
        end
        result_idx++;
      end
      pending_o = pending_results.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the double-ended queue testbench: clock, reset, command stimulus and verdict.
module tb_top
  import deq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CmdReservedLo = 3'd6;
  localparam logic [2:0] CmdReservedHi = 3'd7;
  localparam int HoldOffCycles = 400;
  localparam int WatchdogLimit = 4000;
  localparam int TailCycles = 8;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  deq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  deq_out_t out_data_o;
  int       errors;
  int       pending;
  bit       quiet_phase;
  bit       hold_off_req;

  always #4 clk_i = ~clk_i;

  double_ended_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  deq_result_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic deq_in_t make_command(input cmd_e op, input logic [DataW-1:0] val,
                                           input logic [PosW-1:0] pos);
    deq_in_t item;
    item.cmd = op;
    item.value = val;
    item.position = pos;
    return item;
  endfunction

  function automatic deq_in_t random_command(input phase_e ph);
    deq_in_t item;
    int      r;
    r = $urandom_range(0, 99);
    item.value = $urandom;
    case ($urandom_range(0, 31))
      0: item.value = 32'sh8000_0000;
      1: item.value = 32'sh7FFF_FFFF;
      2: item.value = '0;
      3: item.value = '1;
      default: begin
      end
    endcase
    item.position = $urandom_range(0, 1) ? PosW'($urandom_range(0, 255))
                                         : PosW'($urandom_range(0, 15));
    case (ph)
      PH_FILL: begin
        if (r < 46) item.cmd = CMD_PUSH_FRONT;
        else if (r < 92) item.cmd = CMD_PUSH_BACK;
        else if (r < 97) item.cmd = CMD_READ;
        else if (r < 99) item.cmd = CMD_POP_FRONT;
        else item.cmd = CMD_POP_BACK;
      end
      PH_DRAIN: begin
        if (r < 46) item.cmd = CMD_POP_FRONT;
        else if (r < 92) item.cmd = CMD_POP_BACK;
        else if (r < 97) item.cmd = CMD_READ;
        else if (r < 99) item.cmd = CMD_PUSH_FRONT;
        else item.cmd = CMD_PUSH_BACK;
      end
      default: begin
        if (r < 20) item.cmd = CMD_PUSH_FRONT;
        else if (r < 40) item.cmd = CMD_PUSH_BACK;
        else if (r < 55) item.cmd = CMD_POP_FRONT;
        else if (r < 70) item.cmd = CMD_POP_BACK;
        else if (r < 92) item.cmd = CMD_READ;
        else if (r < 95) item.cmd = CMD_CLEAR;
        else if (r < 98) item.cmd = cmd_e'(CmdReservedLo);
        else item.cmd = cmd_e'(CmdReservedHi);
      end
    endcase
    return item;
  endfunction

  task automatic issue_command(input deq_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input phase_e ph, input int n);
    quiet_phase = ($urandom_range(0, 3) == 0);
    repeat (n) issue_command(random_command(ph));
  endtask

  initial begin : rx_side
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left = 0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HoldOffCycles;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (free_left > 0) begin
          free_left--;
        end else begin
          stall_left = pick_gap();
          free_left = $urandom_range(0, 8);
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni === 1'b1);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    quiet_phase = 1'b0;
    hold_off_req = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue_command(make_command(CMD_POP_FRONT, '1, '1));
    issue_command(make_command(CMD_POP_BACK, '0, '0));
    issue_command(make_command(CMD_READ, '0, 8'd0));
    issue_command(make_command(CMD_READ, '1, 8'd255));
    issue_command(make_command(CMD_PUSH_FRONT, 32'h8000_0000, 8'd0));
    issue_command(make_command(CMD_PUSH_BACK, 32'h7FFF_FFFF, 8'd255));
    issue_command(make_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 8'd0));
    issue_command(make_command(CMD_PUSH_BACK, 32'h0000_0000, 8'd0));
    issue_command(make_command(CMD_PUSH_BACK, 32'h5555_5555, 8'h55));
    issue_command(make_command(CMD_PUSH_FRONT, 32'hAAAA_AAAA, 8'hAA));
    issue_command(make_command(CMD_READ, '0, 8'd0));
    issue_command(make_command(CMD_READ, '0, 8'd1));
    issue_command(make_command(CMD_READ, '0, 8'd5));
    issue_command(make_command(CMD_READ, '0, 8'd6));
    issue_command(make_command(CMD_READ, '0, 8'd255));
    issue_command(make_command(cmd_e'(CmdReservedLo), '1, '1));
    issue_command(make_command(cmd_e'(CmdReservedHi), '0, '0));
    issue_command(make_command(CMD_POP_FRONT, '0, '0));
    issue_command(make_command(CMD_POP_BACK, '0, '0));
    issue_command(make_command(CMD_CLEAR, '1, '1));
    issue_command(make_command(CMD_READ, '0, 8'd0));
    issue_command(make_command(CMD_POP_BACK, '0, '0));
    issue_command(make_command(CMD_PUSH_BACK, 32'd123, 8'd0));
    issue_command(make_command(CMD_READ, '0, 8'd0));

    for (int round = 0; round < 2; round++) begin
      if (round == 0) begin
        hold_off_req = 1'b1;
      end
      run_phase(PH_FILL, 300);
      run_phase(PH_MIXED, 120);
      run_phase(PH_DRAIN, 300);
      run_phase(PH_MIXED, 120);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
